// File: hw/rtl/ecc_mcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_mcc_pkg
// Types, parity-tree masks, syndrome table and check function shared by the
// ECC check-and-correct block.
// ----------------------------------------------------------------------------
package ecc_mcc_pkg;

  localparam int DATA_W  = 32;
  localparam int DWA_W   = 15;
  localparam int CPUA_W  = 16;
  localparam int SYN_W   = 6;
  localparam int CB_W    = 7;
  localparam int STAT_W  = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // bank field of the status word: address bits above bit 14, none here
  localparam logic [1:0] STATUS_BANK = 2'b00;
  localparam logic [STAT_W-1:0] LATCH_RESET = '1;
  localparam logic [CB_W-1:0] CB_ZERO = '0;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_SEW = 2'd0,
    REG_DEW = 2'd1,
    REG_CEN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                cmd;
    logic [DWA_W-1:0]    dw_address;
    logic [DATA_W-1:0]   data_word;
    logic [CPUA_W-1:0]   cpu_address;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic                error_seen;
    logic                single_bit;
    logic                wake_request;
    logic [STAT_W-1:0]   status_word;
    logic [CPUA_W-1:0]   error_address;
  } out_item_t;

  // item held between the store read and the check
  typedef struct packed {
    logic                cmd;
    logic [DATA_W-1:0]   data_word;
    logic [CPUA_W-1:0]   cpu_address;
  } stage_t;

  typedef struct packed {
    logic single_error_wake_off;
    logic double_error_wake_off;
    logic correct_enable;
  } cfg_t;

  typedef struct packed {
    logic [SYN_W-1:0] syn;
    logic             perr;
  } chk_t;

  // WD(n) numbering: bit 31-n, WD00 is the MSB
  function automatic logic [DATA_W-1:0] wd(int n);
    return DATA_W'(1) << (DATA_W - 1 - n);
  endfunction

  localparam logic [DATA_W-1:0] M75 = wd(1) | wd(4) | wd(8) | wd(11) | wd(15) |
                                      wd(19) | wd(23) | wd(26) | wd(30);
  localparam logic [DATA_W-1:0] M76 = wd(0) | wd(3) | wd(6) | wd(10) | wd(13) |
                                      wd(17) | wd(21) | wd(25) | wd(28);
  localparam logic [DATA_W-1:0] M86 = wd(2) | wd(5) | wd(9) | wd(12) | wd(16) |
                                      wd(20) | wd(24) | wd(27) | wd(31);
  localparam logic [DATA_W-1:0] M64 = wd(1) | wd(2) | wd(3) | wd(7) | wd(8) |
                                      wd(9) | wd(10) | wd(14) | wd(15);
  localparam logic [DATA_W-1:0] M85 = wd(16) | wd(17) | wd(22) | wd(23) | wd(24) |
                                      wd(25) | wd(29) | wd(30) | wd(31);
  localparam logic [DATA_W-1:0] M66 = wd(4) | wd(5) | wd(6) | wd(7) | wd(8) |
                                      wd(9) | wd(10);
  localparam logic [DATA_W-1:0] M84 = wd(18) | wd(19) | wd(20) | wd(21) | wd(22) |
                                      wd(23) | wd(24) | wd(25);
  localparam logic [DATA_W-1:0] M63 = wd(11) | wd(12) | wd(13) | wd(14) | wd(15) |
                                      wd(16) | wd(17);
  localparam logic [DATA_W-1:0] M87 = wd(26) | wd(27) | wd(28) | wd(29) | wd(30) |
                                      wd(31);
  localparam logic [DATA_W-1:0] M54 = wd(0) | wd(1) | wd(2) | wd(3);

  // table entry: [5] names a bit, [4:0] data bit to flip
  localparam logic [5:0] SYN_NONE = 6'b0;

  function automatic logic [5:0] syn_hit(int n);
    return {1'b1, 5'(n)};
  endfunction

  localparam logic [5:0] SYN_TABLE [64] = '{
    SYN_NONE,   SYN_NONE,   SYN_NONE,   syn_hit(0),
    SYN_NONE,   syn_hit(1), syn_hit(2), syn_hit(3),
    SYN_NONE,   syn_hit(4), syn_hit(5), syn_hit(6),
    syn_hit(7), syn_hit(8), syn_hit(9), syn_hit(10),
    SYN_NONE,   syn_hit(11), syn_hit(12), syn_hit(13),
    syn_hit(14), syn_hit(15), syn_hit(16), syn_hit(17),
    SYN_NONE,   SYN_NONE,   SYN_NONE,   SYN_NONE,
    SYN_NONE,   syn_hit(1), SYN_NONE,   SYN_NONE,
    SYN_NONE,   syn_hit(26), syn_hit(27), syn_hit(28),
    syn_hit(29), syn_hit(30), syn_hit(31), SYN_NONE,
    SYN_NONE,   SYN_NONE,   SYN_NONE,   SYN_NONE,
    SYN_NONE,   syn_hit(1), SYN_NONE,   SYN_NONE,
    syn_hit(18), syn_hit(19), syn_hit(20), syn_hit(21),
    syn_hit(22), syn_hit(23), syn_hit(24), syn_hit(25),
    SYN_NONE,   SYN_NONE,   SYN_NONE,   SYN_NONE,
    SYN_NONE,   syn_hit(1), SYN_NONE,   SYN_NONE
  };

  // Syndrome and parity error of a data word against a check byte.
  // With a zero check byte the result is the check byte to store.
  function automatic chk_t ecc_check(logic [DATA_W-1:0] d, logic [CB_W-1:0] cb);
    logic h0, h1, h2, h3, h4, h5, rp;
    logic c0a, c0b, c1a, c2a, c2b, c3a, cpa, c34, c4a, cpb, h02;
    chk_t r;
    h0  = cb[6];
    h1  = cb[5];
    h2  = cb[4];
    h3  = cb[3];
    h4  = cb[2];
    h5  = cb[1];
    rp  = cb[0];
    c0a = ~(^(d & M75));
    c0b = ^(d & M76);
    c1a = ^(d & M86);
    c2a = ~(^(d & M64));
    c2b = ^(d & M85);
    h02 = h0 ^ h1 ^ h2;
    c3a = ~(^(d & M66) ^ h3);
    cpa = ~(^(d & M84));
    c34 = ~cpa;
    c4a = ~(^(d & M63) ^ h4);
    cpb = ^(d & M87) ^ h5;
    r.syn[5] = h0 ^ c0a ^ c0b;
    r.syn[4] = h1 ^ c1a ^ c0b;
    r.syn[3] = c2a ^ c2b ^ h2;
    r.syn[2] = c3a ^ c34;
    r.syn[1] = c4a ^ c34;
    r.syn[0] = ~cpb;
    r.perr   = c3a ^ c4a ^ cpa ^ cpb ^ h02 ^ (^(d & M54)) ^ rp;
    return r;
  endfunction

endpackage

// File: hw/rtl/ecc_mcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_mcc_ram
// Generic single-port synchronous RAM, registered read, no reset.
// ----------------------------------------------------------------------------
module ecc_mcc_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // rdata holds its value while en is low and during a write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hw/rtl/ecc_mcc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_mcc_cfg
// APB register file: wake suppress bits and correction enable.
// ----------------------------------------------------------------------------
module ecc_mcc_cfg
  import ecc_mcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_error_wake_off <= 1'b1;
      cfg.double_error_wake_off <= 1'b1;
      cfg.correct_enable        <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SEW: cfg.single_error_wake_off <= pwdata[0];
        REG_DEW: cfg.double_error_wake_off <= pwdata[0];
        REG_CEN: cfg.correct_enable        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SEW: prdata[0] = cfg.single_error_wake_off;
      REG_DEW: prdata[0] = cfg.double_error_wake_off;
      REG_CEN: prdata[0] = cfg.correct_enable;
      default: prdata    = '0;
    endcase
  end

endmodule

// File: hw/rtl/ecc_mcc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_mcc_check
// Syndrome check of a read against its stored check byte, error
// classification, correction and first-error status latch.
// ----------------------------------------------------------------------------
module ecc_mcc_check
  import ecc_mcc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            take,
  input  stage_t          item,
  input  logic [CB_W-1:0] cb_stored,
  output out_item_t       result
);

  logic              error_latched;
  logic [STAT_W-1:0] latched_status;
  logic [CPUA_W-1:0] latched_address;
  logic [STAT_W-1:0] latched_status_next;
  logic [CPUA_W-1:0] latched_address_next;

  logic [CB_W-1:0]   cb;
  chk_t              chk;
  logic [5:0]        entry;
  logic              err;
  logic              single;
  logic              latch_set;

  assign cb    = item.cmd ? CB_ZERO : cb_stored;
  assign chk   = ecc_check(item.data_word, cb);
  assign entry = SYN_TABLE[chk.syn];
  assign err   = ~item.cmd & (chk.perr | (|chk.syn));
  assign single = err & entry[5];
  assign latch_set = take & err & ~error_latched;

  always_comb begin
    latched_status_next  = latched_status;
    latched_address_next = latched_address;
    if (latch_set) begin
      latched_status_next  = {cb[6:1], chk.perr, cb[0], chk.syn, STATUS_BANK};
      latched_address_next = item.cpu_address;
    end
  end

  always_comb begin
    result.data_out = item.data_word;
    if (single && cfg.correct_enable) begin
      result.data_out = item.data_word ^ (DATA_W'(1) << entry[4:0]);
    end
    result.error_seen    = err;
    result.single_bit    = single;
    result.wake_request  = err & (entry[5] ? ~cfg.single_error_wake_off
                                           : ~cfg.double_error_wake_off);
    result.status_word   = latched_status_next;
    result.error_address = latched_address_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_latched   <= 1'b0;
      latched_status  <= LATCH_RESET;
      latched_address <= LATCH_RESET;
    end else begin
      if (latch_set) begin
        error_latched <= 1'b1;
      end
      latched_status  <= latched_status_next;
      latched_address <= latched_address_next;
    end
  end

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("error latch cleared without reset");

  a_latch_frozen: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> $stable(latched_status) && $stable(latched_address))
    else $error("latched status changed after first error");

  a_wake_needs_err: assert property (@(posedge clk) disable iff (rst)
    take && (result.wake_request || result.single_bit) |-> result.error_seen)
    else $error("wake or single-bit flag without error");

endmodule

// File: hw/rtl/ecc_memory_check_and_correct_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_memory_check_and_correct_top
// SEC-DED check byte generator and checker for a memory of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transaction per word access. cmd=1 writes the check
//                 byte generated from data_word at dw_address; cmd=0 checks
//                 data_word against the stored byte.
//   out channel : one transaction per input transaction, in order: returned
//                 (possibly corrected) data, error flags, wake request and
//                 the first-error status and address latch.
//   APB port    : three 1-bit registers at 0x0, 0x4, 0x8; write while idle.
// Timing: one transaction per cycle sustained while out_stall is low.
//   Stage 1 is the check-store read (one synchronous RAM port), stage 2
//   the syndrome check and output register.
// Reset: status and address latch go to all ones, error latch clears,
//   config registers return to 1. The check store is not cleared;
//   reading a word never written returns an unspecified check result.
// Stall: out_stall holds the output register; in_stall rises once the
//   read stage is also full, without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module ecc_memory_check_and_correct_top
  import ecc_mcc_pkg::*;
#(
  parameter int WORDS = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW       = $clog2(WORDS);
  localparam longint AMAX = (longint'(1) << DWA_W) - 1;
  // dw_address / WORDS stays below 2**QSTEPS
  localparam int QSTEPS   = (DWA_W >= AW) ? DWA_W - AW + 1 : 1;

  cfg_t             cfg;
  logic             in_take;
  logic             s1_valid;
  logic             s1_move;
  logic             out_free;
  stage_t           s1_item;
  logic [DWA_W-1:0] addr_mod;
  logic [AW-1:0]    ram_addr;
  logic [CB_W-1:0]  cb_new;
  logic [CB_W-1:0]  cb_rd;
  chk_t             chk_wr;
  out_item_t        result;

  assign out_free = ~out_valid | ~out_stall;
  assign s1_move  = s1_valid & out_free;
  assign in_stall = s1_valid & ~s1_move;
  assign in_take  = in_valid & ~in_stall;

  // address modulo WORDS by restoring subtraction of WORDS << k
  always_comb begin
    addr_mod = in_data.dw_address;
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      if ((longint'(WORDS) << k) <= AMAX) begin
        if (addr_mod >= DWA_W'(longint'(WORDS) << k)) begin
          addr_mod = addr_mod - DWA_W'(longint'(WORDS) << k);
        end
      end
    end
  end

  assign ram_addr = AW'(addr_mod);
  assign chk_wr   = ecc_check(in_data.data_word, CB_ZERO);
  assign cb_new   = {chk_wr.syn, chk_wr.perr};

  // writes land at accept; a following read of the same word is issued at
  // its own later accept and sees the new byte, so no forwarding is needed
  ecc_mcc_ram #(
    .WIDTH (CB_W),
    .DEPTH (WORDS)
  ) u_store (
    .clk   (clk),
    .en    (in_take),
    .we    (in_data.cmd),
    .addr  (ram_addr),
    .wdata (cb_new),
    .rdata (cb_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.cmd         <= in_data.cmd;
      s1_item.data_word   <= in_data.data_word;
      s1_item.cpu_address <= in_data.cpu_address;
    end
  end

  ecc_mcc_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (s1_move),
    .item      (s1_item),
    .cb_stored (cb_rd),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= result;
    end
  end

  ecc_mcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted transaction not held in read stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_item) && $stable(cb_rd))
    else $error("read stage lost its transaction or store data while stalled");

  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("checked transaction not presented on output");

endmodule
